>>> design/tipg_pkg.sv
package tipg_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_PILOT_COUNT_HEADER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PILOT_COUNT_DATA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PILOT_HALF_US      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST_US      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND_US     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_PULSE_US      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_PULSE_US       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_US           = 3'd7;

    localparam logic [13:0] RST_PILOT_COUNT_HEADER = 14'd8063;
    localparam logic [13:0] RST_PILOT_COUNT_DATA   = 14'd3223;
    localparam logic [11:0] RST_PILOT_HALF_US      = 12'd619;
    localparam logic [11:0] RST_SYNC_FIRST_US      = 12'd191;
    localparam logic [11:0] RST_SYNC_SECOND_US     = 12'd210;
    localparam logic [11:0] RST_ZERO_PULSE_US      = 12'd244;
    localparam logic [11:0] RST_ONE_PULSE_US       = 12'd489;
    localparam logic [19:0] RST_PAUSE_US           = 20'd1000000;

    localparam logic [2:0] TONE_SILENCE = 3'd0;
    localparam logic [2:0] TONE_PILOT   = 3'd1;
    localparam logic [2:0] TONE_SYNC1   = 3'd2;
    localparam logic [2:0] TONE_SYNC2   = 3'd3;
    localparam logic [2:0] TONE_ZERO    = 3'd4;
    localparam logic [2:0] TONE_ONE     = 3'd5;

    // Segment sequence of one job: preamble, eight bits, pause
    localparam logic [3:0] STEP_PILOT    = 4'd0;
    localparam logic [3:0] STEP_SYNC1    = 4'd1;
    localparam logic [3:0] STEP_SYNC2    = 4'd2;
    localparam logic [3:0] STEP_GAP      = 4'd3;
    localparam logic [3:0] STEP_BIT_MSB  = 4'd4;
    localparam logic [3:0] STEP_BIT_LSB  = 4'd11;
    localparam logic [3:0] STEP_PAUSE    = 4'd12;

    typedef struct packed {
        logic [13:0] pilot_count_header;
        logic [13:0] pilot_count_data;
        logic [11:0] pilot_half_us;
        logic [11:0] sync_first_us;
        logic [11:0] sync_second_us;
        logic [11:0] zero_pulse_us;
        logic [11:0] one_pulse_us;
        logic [19:0] pause_us;
    } cfg_t;

    typedef struct packed {
        logic       preamble;
        logic       flag_zero;
        logic       bits;
        logic       pause;
        logic [7:0] data;
    } job_t;

    typedef struct packed {
        logic [2:0]  tone;
        logic [19:0] duration_us;
        logic [14:0] repeat_res;
        logic        last;
    } seg_t;

endpackage

>>> design/tape_image_pulse_generator_top.sv
// Tape image pulse generator: one tape byte in, up to thirteen tone segments out.
// Path: a byte's job passes the job queue and the back sequencer's job register before
// its segments reach the result queue. Throughput: one segment per cycle from the back
// sequencer while the result queue has room, so a data byte gives eight segments
// (twelve with the block preamble, one more with the pause). Reset clears the parser
// to expect a length low byte, empties both queues and loads the register defaults.
module tape_image_pulse_generator_top
    import tipg_pkg::*;
#(
    parameter int unsigned JOB_DEPTH = 2,
    parameter int unsigned OUT_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            tap_byte,
    input  logic                  image_end,
    output logic                  empty,
    input  logic                  pop,
    output logic [2:0]            tone,
    output logic [19:0]           duration_us,
    output logic [14:0]           repeat_res,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic in_accept;
    logic job_valid;
    job_t front_job;
    logic job_full;
    logic job_empty;
    logic job_pop;
    job_t back_job;
    logic seg_valid;
    seg_t seg;
    logic seg_full;
    seg_t out_seg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pilot_count_header <= RST_PILOT_COUNT_HEADER;
            cfg_reg.pilot_count_data   <= RST_PILOT_COUNT_DATA;
            cfg_reg.pilot_half_us      <= RST_PILOT_HALF_US;
            cfg_reg.sync_first_us      <= RST_SYNC_FIRST_US;
            cfg_reg.sync_second_us     <= RST_SYNC_SECOND_US;
            cfg_reg.zero_pulse_us      <= RST_ZERO_PULSE_US;
            cfg_reg.one_pulse_us       <= RST_ONE_PULSE_US;
            cfg_reg.pause_us           <= RST_PAUSE_US;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PILOT_COUNT_HEADER: cfg_reg.pilot_count_header <= cfg_data[13:0];
                REG_PILOT_COUNT_DATA:   cfg_reg.pilot_count_data   <= cfg_data[13:0];
                REG_PILOT_HALF_US:      cfg_reg.pilot_half_us      <= cfg_data[11:0];
                REG_SYNC_FIRST_US:      cfg_reg.sync_first_us      <= cfg_data[11:0];
                REG_SYNC_SECOND_US:     cfg_reg.sync_second_us     <= cfg_data[11:0];
                REG_ZERO_PULSE_US:      cfg_reg.zero_pulse_us      <= cfg_data[11:0];
                REG_ONE_PULSE_US:       cfg_reg.one_pulse_us       <= cfg_data[11:0];
                REG_PAUSE_US:           cfg_reg.pause_us           <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold input whenever the job queue cannot take a job
    assign full      = job_full;
    assign in_accept = push && !job_full;

    tipg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .tap_byte  (tap_byte),
        .image_end (image_end),
        .job_valid (job_valid),
        .job       (front_job)
    );

    tipg_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept && job_valid),
        .wr_data (front_job),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (back_job),
        .empty   (job_empty)
    );

    tipg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_in    (back_job),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .seg_valid (seg_valid),
        .seg       (seg),
        .seg_full  (seg_full)
    );

    tipg_fifo #(
        .WIDTH ($bits(seg_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (seg_valid),
        .wr_data (seg),
        .full    (seg_full),
        .rd_en   (pop),
        .rd_data (out_seg),
        .empty   (empty)
    );

    assign tone        = out_seg.tone;
    assign duration_us = out_seg.duration_us;
    assign repeat_res  = out_seg.repeat_res;
    assign last        = out_seg.last;

endmodule

>>> design/tipg_fifo.sv
module tipg_fifo
    import tipg_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> design/tipg_front.sv
module tipg_front
    import tipg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] tap_byte,
    input  logic       image_end,
    output logic       job_valid,
    output job_t       job
);

    typedef enum logic [2:0] {
        PH_LEN_LO = 3'b001,
        PH_LEN_HI = 3'b010,
        PH_DATA   = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] block_length_reg, block_length_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] full_length;
    logic [15:0] left_dec;

    assign full_length = {tap_byte, block_length_reg[7:0]};
    assign left_dec    = bytes_left_reg - 16'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        block_length_next = block_length_reg;
        bytes_left_next   = bytes_left_reg;
        job_valid         = 1'b0;
        job.preamble      = 1'b0;
        job.flag_zero     = (tap_byte == 8'd0);
        job.bits          = 1'b0;
        job.pause         = 1'b0;
        job.data          = tap_byte;
        unique case (phase_reg)
            PH_LEN_LO:
            begin
                block_length_next = {block_length_reg[15:8], tap_byte};
                phase_next        = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                block_length_next = full_length;
                bytes_left_next   = full_length;
                if (full_length == 16'd0 || image_end)
                begin
                    job_valid  = 1'b1;
                    job.pause  = 1'b1;
                    phase_next = PH_LEN_LO;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                job_valid       = 1'b1;
                job.preamble    = (bytes_left_reg == block_length_reg);
                job.bits        = 1'b1;
                bytes_left_next = left_dec;
                if (left_dec == 16'd0 || image_end)
                begin
                    job.pause  = 1'b1;
                    phase_next = PH_LEN_LO;
                end
            end
            default:
            begin
                phase_next = PH_LEN_LO;
            end
        endcase
        if (image_end)
        begin
            phase_next      = PH_LEN_LO;
            bytes_left_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEN_LO;
            block_length_reg <= '0;
            bytes_left_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            block_length_reg <= block_length_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

endmodule

>>> design/tipg_back.sv
module tipg_back
    import tipg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  job_t job_in,
    input  logic job_empty,
    output logic job_pop,
    output logic seg_valid,
    output seg_t seg,
    input  logic seg_full
);

    logic       active_reg, active_next;
    job_t       job_reg, job_next;
    logic [3:0] step_reg, step_next;
    logic [3:0] end_step;
    logic [3:0] start_step;
    logic [2:0] bit_idx;
    logic       bit_val;
    logic       seg_done;
    logic       load;

    assign end_step   = job_reg.pause ? STEP_PAUSE : STEP_BIT_LSB;
    assign start_step = job_in.preamble ? STEP_PILOT :
                        (job_in.bits ? STEP_BIT_MSB : STEP_PAUSE);
    assign bit_idx    = 3'(step_reg - STEP_BIT_MSB);
    assign bit_val    = job_reg.data[3'd7 - bit_idx];

    assign seg_valid = active_reg;
    assign seg_done  = active_reg && !seg_full;
    // Load the next job on the last segment so that jobs run without a gap
    assign load      = !job_empty && (!active_reg || (seg_done && step_reg == end_step));
    assign job_pop   = load;

    always_comb
    begin
        seg.last       = (step_reg == end_step);
        seg.repeat_res = 15'd1;
        seg.tone       = TONE_SILENCE;
        seg.duration_us = cfg.pause_us;
        if (step_reg == STEP_PILOT)
        begin
            seg.tone        = TONE_PILOT;
            seg.duration_us = 20'(cfg.pilot_half_us);
            seg.repeat_res  = job_reg.flag_zero ?
                              15'(cfg.pilot_count_header) + 15'd1 :
                              15'(cfg.pilot_count_data) + 15'd1;
        end
        else if (step_reg == STEP_SYNC1)
        begin
            seg.tone        = TONE_SYNC1;
            seg.duration_us = 20'(cfg.sync_first_us);
        end
        else if (step_reg == STEP_SYNC2)
        begin
            seg.tone        = TONE_SYNC2;
            seg.duration_us = 20'(cfg.sync_second_us);
        end
        else if (step_reg == STEP_GAP)
        begin
            seg.tone        = TONE_SILENCE;
            seg.duration_us = 20'(cfg.sync_second_us);
        end
        else if (step_reg <= STEP_BIT_LSB)
        begin
            seg.tone        = bit_val ? TONE_ONE : TONE_ZERO;
            seg.duration_us = bit_val ? 20'(cfg.one_pulse_us) : 20'(cfg.zero_pulse_us);
        end
    end

    always_comb
    begin
        active_next = active_reg;
        job_next    = job_reg;
        step_next   = step_reg;
        if (seg_done)
        begin
            if (step_reg == end_step)
            begin
                active_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 4'd1;
            end
        end
        if (load)
        begin
            active_next = 1'b1;
            job_next    = job_in;
            step_next   = start_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= STEP_PILOT;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import tipg_pkg::*;

    typedef enum logic [1:0] {
        EXPECT_LEN_LO,
        EXPECT_LEN_HI,
        IN_DATA
    } parse_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       image_last;
    } tap_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            tap_byte = 8'h00;
    logic                  image_end = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [2:0]            tone;
    logic [19:0]           duration_us;
    logic [14:0]           repeat_res;
    logic                  last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tape_image_pulse_generator_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .tap_byte    (tap_byte),
        .image_end   (image_end),
        .empty       (empty),
        .pop         (pop),
        .tone        (tone),
        .duration_us (duration_us),
        .repeat_res  (repeat_res),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // shadow of the block's registers and parser
    cfg_t         shadow_cfg;
    parse_state_t parse_st;
    logic [15:0]  blk_len;
    logic [15:0]  bytes_left;

    tap_item_t tap_pending [$];
    seg_t      seg_expect [$];
    seg_t      want;

    int errors = 0;
    int bytes_taken = 0;
    int segs_checked = 0;
    int blocks_opened = 0;
    int settings_used = 1;

    bit quiet = 1'b0;
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int gap_left = 0;
    int stall_left = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic seg_t make_seg(input logic [2:0] t, input logic [19:0] d,
                                      input logic [14:0] r);
        seg_t s;
        s.tone        = t;
        s.duration_us = d;
        s.repeat_res  = r;
        s.last        = 1'b0;
        return s;
    endfunction

    // Work out the tone segments one accepted tape byte produces.
    function automatic void predict_segments(input logic [7:0] b, input logic end_flag);
        seg_t        segs [13];
        int          n;
        logic        close_blk;
        logic [13:0] cnt;
        n = 0;
        close_blk = 1'b0;
        case (parse_st)
            EXPECT_LEN_LO: begin
                blk_len = {8'h00, b};
                parse_st = EXPECT_LEN_HI;
            end
            EXPECT_LEN_HI: begin
                blk_len = {b, blk_len[7:0]};
                bytes_left = blk_len;
                if (blk_len == 16'd0 || end_flag) begin
                    close_blk = 1'b1;
                    parse_st = EXPECT_LEN_LO;
                end else begin
                    parse_st = IN_DATA;
                end
            end
            default: begin
                // flag byte opens the block with pilot and sync
                if (bytes_left == blk_len) begin
                    cnt = (b == 8'h00) ? shadow_cfg.pilot_count_header
                                       : shadow_cfg.pilot_count_data;
                    segs[n] = make_seg(TONE_PILOT, 20'(shadow_cfg.pilot_half_us),
                                       {1'b0, cnt} + 15'd1);
                    segs[n+1] = make_seg(TONE_SYNC1, 20'(shadow_cfg.sync_first_us), 15'd1);
                    segs[n+2] = make_seg(TONE_SYNC2, 20'(shadow_cfg.sync_second_us), 15'd1);
                    segs[n+3] = make_seg(TONE_SILENCE, 20'(shadow_cfg.sync_second_us), 15'd1);
                    n = n + 4;
                    blocks_opened++;
                end
                for (int k = 7; k >= 0; k--) begin
                    if (b[k])
                        segs[n] = make_seg(TONE_ONE, 20'(shadow_cfg.one_pulse_us), 15'd1);
                    else
                        segs[n] = make_seg(TONE_ZERO, 20'(shadow_cfg.zero_pulse_us), 15'd1);
                    n++;
                end
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0 || end_flag) begin
                    close_blk = 1'b1;
                    parse_st = EXPECT_LEN_LO;
                end
            end
        endcase
        if (close_blk) begin
            segs[n] = make_seg(TONE_SILENCE, shadow_cfg.pause_us, 15'd1);
            n++;
        end
        if (end_flag) begin
            parse_st = EXPECT_LEN_LO;
            bytes_left = 16'd0;
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1)
                segs[i].last = 1'b1;
            seg_expect.push_back(segs[i]);
        end
    endfunction

    // Byte driver
    always @(posedge clk) begin
        if (push && !full) begin
            predict_segments(tap_byte, image_end);
            bytes_taken++;
        end
        if (push && full) begin
            // hold the offered transaction
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            push <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 2);
            push <= 1'b0;
        end else if (tap_pending.size() > 0) begin
            tap_item_t it;
            it = tap_pending.pop_front();
            tap_byte <= it.data;
            image_end <= it.image_last;
            push <= 1'b1;
        end else begin
            push <= 1'b0;
        end
    end

    // Segment monitor
    always @(posedge clk) begin
        if (pop && !empty) begin
            segs_checked++;
            if (seg_expect.size() == 0) begin
                $error("unexpected segment: tone %0d duration %0d repeat %0d",
                       tone, duration_us, repeat_res);
                errors++;
            end else begin
                want = seg_expect.pop_front();
                if (tone !== want.tone) begin
                    $error("tone: expected %0d, got %0d", want.tone, tone);
                    errors++;
                end
                if (duration_us !== want.duration_us) begin
                    $error("duration_us: expected %0d, got %0d", want.duration_us, duration_us);
                    errors++;
                end
                if (repeat_res !== want.repeat_res) begin
                    $error("repeat_res: expected %0d, got %0d", want.repeat_res, repeat_res);
                    errors++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    errors++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            // long hold-off so the block backs up into its input
            hold_left <= 400;
            hold_done <= 1'b1;
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 2);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        tap_item_t it;
        it.data = b;
        it.image_last = fin;
        tap_pending.push_back(it);
    endtask

    task automatic queue_random_blocks(input int target);
        int added;
        int kind;
        int len;
        added = 0;
        while (added < target) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                len = $urandom_range(1, 5);
                queue_byte(8'(len), 1'b0);
                queue_byte(8'h00, 1'b0);
                for (int i = 0; i < len; i++) begin
                    if (i == 0 && $urandom_range(0, 2) == 0)
                        queue_byte(8'h00, 1'b0);
                    else
                        queue_byte(8'($urandom_range(0, 255)),
                                   (i == len - 1) && ($urandom_range(0, 3) == 0));
                end
                added += len + 2;
            end else if (kind == 6) begin
                queue_byte(8'h00, 1'b0);
                queue_byte(8'h00, 1'($urandom_range(0, 1)));
                added += 2;
            end else if (kind == 7) begin
                // long length cut short by the end of the image
                len = $urandom_range(1, 4);
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
                queue_byte(8'($urandom_range(1, 255)), 1'b0);
                for (int i = 0; i < len; i++)
                    queue_byte(8'($urandom_range(0, 255)), i == len - 1);
                added += len + 2;
            end else if (kind == 8) begin
                queue_byte(8'($urandom_range(0, 255)), 1'b1);
                added += 1;
            end else begin
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
                queue_byte(8'($urandom_range(0, 255)), 1'b1);
                added += 2;
            end
        end
    endtask

    // Let everything drain, then allow for a byte still in flight.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (tap_pending.size() != 0 || push || seg_expect.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Called at a rising edge; leaves cfg_valid high for back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PILOT_COUNT_HEADER: shadow_cfg.pilot_count_header = val[13:0];
            REG_PILOT_COUNT_DATA:   shadow_cfg.pilot_count_data = val[13:0];
            REG_PILOT_HALF_US:      shadow_cfg.pilot_half_us = val[11:0];
            REG_SYNC_FIRST_US:      shadow_cfg.sync_first_us = val[11:0];
            REG_SYNC_SECOND_US:     shadow_cfg.sync_second_us = val[11:0];
            REG_ZERO_PULSE_US:      shadow_cfg.zero_pulse_us = val[11:0];
            REG_ONE_PULSE_US:       shadow_cfg.one_pulse_us = val[11:0];
            default:                shadow_cfg.pause_us = val;
        endcase
    endtask

    task automatic load_settings(input int hdr, input int dat, input int pil, input int s1,
                                 input int s2, input int z, input int o, input int p);
        wait_idle();
        @(posedge clk);
        write_reg(REG_PILOT_COUNT_HEADER, CFG_DATA_W'(hdr));
        write_reg(REG_PILOT_COUNT_DATA, CFG_DATA_W'(dat));
        write_reg(REG_PILOT_HALF_US, CFG_DATA_W'(pil));
        write_reg(REG_SYNC_FIRST_US, CFG_DATA_W'(s1));
        write_reg(REG_SYNC_SECOND_US, CFG_DATA_W'(s2));
        write_reg(REG_ZERO_PULSE_US, CFG_DATA_W'(z));
        write_reg(REG_ONE_PULSE_US, CFG_DATA_W'(o));
        write_reg(REG_PAUSE_US, CFG_DATA_W'(p));
        cfg_valid <= 1'b0;
        settings_used++;
        @(negedge clk);
    endtask

    initial begin
        shadow_cfg.pilot_count_header = RST_PILOT_COUNT_HEADER;
        shadow_cfg.pilot_count_data   = RST_PILOT_COUNT_DATA;
        shadow_cfg.pilot_half_us      = RST_PILOT_HALF_US;
        shadow_cfg.sync_first_us      = RST_SYNC_FIRST_US;
        shadow_cfg.sync_second_us     = RST_SYNC_SECOND_US;
        shadow_cfg.zero_pulse_us      = RST_ZERO_PULSE_US;
        shadow_cfg.one_pulse_us       = RST_ONE_PULSE_US;
        shadow_cfg.pause_us           = RST_PAUSE_US;
        parse_st = EXPECT_LEN_LO;
        blk_len = 16'd0;
        bytes_left = 16'd0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // header block with long pilot, then all-ones data
        queue_byte(8'h02, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b0);
        // empty block: pause only
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
        // one-byte block with short pilot
        queue_byte(8'h01, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'hA5, 1'b0);
        // image ends on a length low byte: dropped
        queue_byte(8'h37, 1'b1);
        // image ends on the length high byte of a nonzero length
        queue_byte(8'h05, 1'b0); queue_byte(8'h00, 1'b1);
        // truncated block
        queue_byte(8'h03, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0); queue_byte(8'h80, 1'b1);
        // maximum length, flag byte also ends the image
        queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'h55, 1'b1);
        // empty block at the end of the image
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b1);

        load_settings(0, 0, 1, 1, 1, 1, 1, 0);
        queue_random_blocks(30);

        load_settings(16383, 16383, 4095, 4095, 4095, 4095, 4095, 1048575);
        queue_random_blocks(28);

        load_settings($urandom_range(0, 16383), $urandom_range(0, 16383),
                      $urandom_range(1, 4095), $urandom_range(1, 4095),
                      $urandom_range(1, 4095), $urandom_range(1, 4095),
                      $urandom_range(1, 4095), $urandom_range(0, 1048575));
        queue_random_blocks(30);
        hold_armed = 1'b1;
        while (tap_pending.size() > 15)
            @(negedge clk);
        quiet = 1'b1;

        do
            @(negedge clk);
        while (tap_pending.size() != 0 || push || seg_expect.size() != 0);
        repeat (20) @(posedge clk);

        $display("Covered %0d tape bytes, %0d blocks opened, %0d tone segments checked",
                 bytes_taken, blocks_opened, segs_checked);
        $display("under %0d register settings, with a long output hold-off", settings_used);
        if (errors == 0 && seg_expect.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout with %0d segments outstanding", seg_expect.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
design/tipg_pkg.sv
design/tipg_fifo.sv
design/tipg_front.sv
design/tipg_back.sv
design/tape_image_pulse_generator_top.sv
dv/tb.sv
